// File: hdl/edf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF scheduler package
// Request/response payload types and the codes shared by the scheduler files.
// ----------------------------------------------------------------------------
package edf_pkg;

  localparam int TIME_W  = 32;
  localparam int STAMP_W = 16;
  localparam int ID_W    = 4;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 2;
  localparam int PLACE_W = 2;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_CREATE       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_TERMINATE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SLEEP        = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SET_DEADLINE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK         = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BLOCK        = 3'd5;
  localparam logic [KIND_W-1:0] KIND_WAKE         = 3'd6;

  // Response status
  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_NO_SLOT = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_NOT_APP = 2'd2;

  // List membership of a slot
  localparam logic [PLACE_W-1:0] PLACE_FREE  = 2'd0;
  localparam logic [PLACE_W-1:0] PLACE_READY = 2'd1;
  localparam logic [PLACE_W-1:0] PLACE_SLEEP = 2'd2;
  localparam logic [PLACE_W-1:0] PLACE_WAIT  = 2'd3;

  localparam logic [TIME_W-1:0]  IDLE_DEADLINE = '1;
  localparam logic [STAMP_W-1:0] STAMP_RESET   = 16'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] deadline_value;
    logic [TIME_W-1:0] sleep_ticks;
    logic [ID_W-1:0]   task_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0]   running_task;
    logic [ID_W-1:0]   new_task;
    logic [STAT_W-1:0] status;
    logic              deadline_passed;
    logic [TIME_W-1:0] tick_now;
  } rsp_t;

endpackage

// File: hdl/edf_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF stream interface
// Valid/ready channel carrying one payload of type T per request.
// ----------------------------------------------------------------------------
interface edf_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/edf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module edf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/edf_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EDF task scheduler
// Earliest-deadline-first scheduler over a table of task slots.
// ----------------------------------------------------------------------------
// One request at a time. Each request is served by a slot scan: one shared
// compare unit visits the task table one slot per cycle (the table RAM read
// is registered). A request costs one pass to find the running task, the
// S_EXEC state to apply the request, one pass to find the new running task
// and the S_DONE handoff. A tick also runs one pass over the sleeping list
// and one over the waiting list, plus one more pass and one S_REL write per
// task it makes ready. Slot 0 is the idle task and is never written; its
// deadline reads as all ones. The response register lets a finished result
// wait while the next request is taken.
module edf_task_scheduler #(
  parameter int MAX_TASKS = 16
) (
  input logic         clk,
  input logic         rst,
  edf_stream_if.sink   req,
  edf_stream_if.source rsp
);

  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int CNT_W = IDX_W + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_REL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [1:0] MODE_RUN   = 2'd0;
  localparam logic [1:0] MODE_SLEEP = 2'd1;
  localparam logic [1:0] MODE_WAIT  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_TASKS);

  // Control state
  logic [2:0]                     state;
  logic [CNT_W-1:0]               cnt;
  logic                           rd_vld;
  logic [1:0]                     mode;
  logic                           final_scan;
  logic [edf_pkg::TIME_W-1:0]     tick_count;
  logic [edf_pkg::STAMP_W-1:0]    stamp_cnt;
  logic [edf_pkg::PLACE_W-1:0]    place [MAX_TASKS];
  logic                           rsp_valid;

  // Scan and request payload
  logic [IDX_W-1:0]               rd_idx;
  logic                           found;
  logic [IDX_W-1:0]               best_idx;
  logic [edf_pkg::TIME_W-1:0]     best_dl;
  logic [edf_pkg::STAMP_W-1:0]    best_st;
  logic                           free_found;
  logic [IDX_W-1:0]               free_idx;
  edf_pkg::req_t                  req_r;
  logic [edf_pkg::STAT_W-1:0]     status_r;
  logic [IDX_W-1:0]               created;
  edf_pkg::rsp_t                  rsp_data;

  // Table RAMs
  logic [IDX_W-1:0]               wr_addr;
  logic                           we_dl, we_wk, we_st;
  logic [edf_pkg::TIME_W-1:0]     wd_dl, wd_wk;
  logic [edf_pkg::STAMP_W-1:0]    wd_st;
  logic [edf_pkg::TIME_W-1:0]     dl_q, wk_q;
  logic [edf_pkg::STAMP_W-1:0]    st_q;
  logic [IDX_W-1:0]               rd_addr;

  assign rd_addr = cnt[IDX_W-1:0];

  edf_ram #(.WIDTH(edf_pkg::TIME_W), .DEPTH(MAX_TASKS)) u_dl_ram (
    .clk(clk), .we(we_dl), .waddr(wr_addr), .wdata(wd_dl), .raddr(rd_addr), .rdata(dl_q)
  );

  edf_ram #(.WIDTH(edf_pkg::TIME_W), .DEPTH(MAX_TASKS)) u_wk_ram (
    .clk(clk), .we(we_wk), .waddr(wr_addr), .wdata(wd_wk), .raddr(rd_addr), .rdata(wk_q)
  );

  edf_ram #(.WIDTH(edf_pkg::STAMP_W), .DEPTH(MAX_TASKS)) u_st_ram (
    .clk(clk), .we(we_st), .waddr(wr_addr), .wdata(wd_st), .raddr(rd_addr), .rdata(st_q)
  );

  // Shared compare unit: filter and list order of the slot under scan
  logic [edf_pkg::TIME_W-1:0]  cand_dl;
  logic [edf_pkg::STAMP_W-1:0] cand_st;
  logic [edf_pkg::PLACE_W-1:0] cand_place;
  logic                        cand_ok;
  logic                        cand_first;
  logic                        take;
  logic                        found_now;

  always_comb begin
    cand_dl    = (rd_idx == '0) ? edf_pkg::IDLE_DEADLINE : dl_q;
    cand_st    = (rd_idx == '0) ? '0 : st_q;
    cand_place = place[rd_idx];
    unique case (mode)
      MODE_RUN:   cand_ok = (cand_place == edf_pkg::PLACE_READY);
      MODE_SLEEP: cand_ok = (cand_place == edf_pkg::PLACE_SLEEP) &&
                            ((tick_count >= wk_q) || (tick_count >= cand_dl));
      MODE_WAIT:  cand_ok = (cand_place == edf_pkg::PLACE_WAIT) &&
                            (tick_count >= cand_dl);
      default:    cand_ok = 1'b0;
    endcase
    cand_first = (cand_dl < best_dl) || ((cand_dl == best_dl) && (cand_st > best_st));
    take       = rd_vld && cand_ok && (!found || cand_first);
    found_now  = found || take;
  end

  // Request decode helpers
  logic                 run_idle;
  logic [IDX_W+3:0]     tid_ext;
  logic [IDX_W-1:0]     tid_idx;
  logic                 wake_ok;
  logic [IDX_W+3:0]     run_ext;
  logic [IDX_W+3:0]     new_ext;

  always_comb begin
    run_idle = (best_idx == '0);
    tid_ext  = {{IDX_W{1'b0}}, req_r.task_id};
    tid_idx  = tid_ext[IDX_W-1:0];
    wake_ok  = (32'(req_r.task_id) < 32'(MAX_TASKS)) &&
               (place[tid_idx] == edf_pkg::PLACE_WAIT);
    run_ext  = {4'b0, best_idx};
    new_ext  = {4'b0, created};
  end

  // Table write port
  always_comb begin
    wr_addr = best_idx;
    we_dl   = 1'b0;
    we_wk   = 1'b0;
    we_st   = 1'b0;
    wd_dl   = req_r.deadline_value;
    wd_wk   = tick_count + req_r.sleep_ticks;
    wd_st   = stamp_cnt;
    if (state == S_EXEC) begin
      unique case (req_r.kind)
        edf_pkg::KIND_CREATE: begin
          wr_addr = free_idx;
          wd_wk   = '0;
          we_dl   = free_found;
          we_wk   = free_found;
          we_st   = free_found;
        end
        edf_pkg::KIND_SLEEP: begin
          we_wk = !run_idle;
          we_st = !run_idle;
        end
        edf_pkg::KIND_SET_DEADLINE: begin
          we_dl = !run_idle;
          we_st = !run_idle;
        end
        edf_pkg::KIND_BLOCK: begin
          we_st = !run_idle;
        end
        edf_pkg::KIND_WAKE: begin
          wr_addr = tid_idx;
          we_st   = wake_ok;
        end
        default: begin
        end
      endcase
    end else if (state == S_REL) begin
      we_st = 1'b1;
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      rd_vld     <= 1'b0;
      mode       <= MODE_RUN;
      final_scan <= 1'b0;
      tick_count <= '0;
      stamp_cnt  <= edf_pkg::STAMP_RESET;
      rsp_valid  <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        place[i] <= (i == 0) ? edf_pkg::PLACE_READY : edf_pkg::PLACE_FREE;
      end
    end else begin
      if (rsp_valid && rsp.ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            req_r      <= req.data;
            status_r   <= edf_pkg::STATUS_OK;
            created    <= '0;
            free_found <= 1'b0;
            cnt        <= '0;
            rd_vld     <= 1'b0;
            found      <= 1'b0;
            mode       <= MODE_RUN;
            final_scan <= 1'b0;
            state      <= S_SCAN;
          end
        end

        // one slot per cycle; the RAM data follows its address in the next cycle
        S_SCAN: begin
          if (cnt != CNT_END) begin
            cnt <= cnt + 1'b1;
          end
          rd_vld <= (cnt < CNT_END);
          rd_idx <= rd_addr;
          if (take) begin
            found    <= 1'b1;
            best_idx <= rd_idx;
            best_dl  <= cand_dl;
            best_st  <= cand_st;
          end
          // lowest free slot above the idle task, noted on the first pass
          if (rd_vld && (mode == MODE_RUN) && !final_scan && !free_found &&
              (rd_idx != '0) && (cand_place == edf_pkg::PLACE_FREE)) begin
            free_found <= 1'b1;
            free_idx   <= rd_idx;
          end
          if (cnt == CNT_END) begin
            unique case (mode)
              MODE_RUN: begin
                state <= final_scan ? S_DONE : S_EXEC;
              end
              MODE_SLEEP: begin
                if (found_now) begin
                  state <= S_REL;
                end else begin
                  cnt    <= '0;
                  rd_vld <= 1'b0;
                  found  <= 1'b0;
                  mode   <= MODE_WAIT;
                end
              end
              default: begin
                if (found_now) begin
                  state <= S_REL;
                end else begin
                  cnt        <= '0;
                  rd_vld     <= 1'b0;
                  found      <= 1'b0;
                  mode       <= MODE_RUN;
                  final_scan <= 1'b1;
                end
              end
            endcase
          end
        end

        // apply the request to the running task, the free slot or the named slot
        S_EXEC: begin
          unique case (req_r.kind)
            edf_pkg::KIND_CREATE: begin
              if (free_found) begin
                place[free_idx] <= edf_pkg::PLACE_READY;
                stamp_cnt       <= stamp_cnt + 1'b1;
                created         <= free_idx;
              end else begin
                status_r <= edf_pkg::STATUS_NO_SLOT;
              end
            end
            edf_pkg::KIND_TERMINATE: begin
              if (run_idle) status_r <= edf_pkg::STATUS_NOT_APP;
              else place[best_idx] <= edf_pkg::PLACE_FREE;
            end
            edf_pkg::KIND_SLEEP: begin
              if (run_idle) begin
                status_r <= edf_pkg::STATUS_NOT_APP;
              end else begin
                place[best_idx] <= edf_pkg::PLACE_SLEEP;
                stamp_cnt       <= stamp_cnt + 1'b1;
              end
            end
            edf_pkg::KIND_SET_DEADLINE: begin
              if (run_idle) begin
                status_r <= edf_pkg::STATUS_NOT_APP;
              end else begin
                place[best_idx] <= edf_pkg::PLACE_READY;
                stamp_cnt       <= stamp_cnt + 1'b1;
              end
            end
            edf_pkg::KIND_TICK: begin
              tick_count <= tick_count + 1'b1;
            end
            edf_pkg::KIND_BLOCK: begin
              if (run_idle) begin
                status_r <= edf_pkg::STATUS_NOT_APP;
              end else begin
                place[best_idx] <= edf_pkg::PLACE_WAIT;
                stamp_cnt       <= stamp_cnt + 1'b1;
              end
            end
            edf_pkg::KIND_WAKE: begin
              if (wake_ok) begin
                place[tid_idx] <= edf_pkg::PLACE_READY;
                stamp_cnt      <= stamp_cnt + 1'b1;
              end else begin
                status_r <= edf_pkg::STATUS_NOT_APP;
              end
            end
            default: begin
              status_r <= edf_pkg::STATUS_NOT_APP;
            end
          endcase
          // a tick goes on to release sleepers, the rest to the final pass
          cnt        <= '0;
          rd_vld     <= 1'b0;
          found      <= 1'b0;
          mode       <= (req_r.kind == edf_pkg::KIND_TICK) ? MODE_SLEEP : MODE_RUN;
          final_scan <= (req_r.kind != edf_pkg::KIND_TICK);
          state      <= S_SCAN;
        end

        // move the first due task of the list to ready, then look again
        S_REL: begin
          place[best_idx] <= edf_pkg::PLACE_READY;
          stamp_cnt       <= stamp_cnt + 1'b1;
          cnt             <= '0;
          rd_vld          <= 1'b0;
          found           <= 1'b0;
          state           <= S_SCAN;
        end

        // hand the result to the response register
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_data.running_task    <= run_ext[3:0];
            rsp_data.new_task        <= new_ext[3:0];
            rsp_data.status          <= status_r;
            rsp_data.deadline_passed <= (tick_count >= best_dl);
            rsp_data.tick_now        <= tick_count;
            rsp_valid                <= 1'b1;
            state                    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
